// ===== sv/ctsc_pkg.sv =====
// Package for the calendar time step counter.
// Holds field widths, request and unit codes, reset values and the month length table.
// No dependencies.
package ctsc_pkg;

    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int NEW_YEAR_W = 14;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_SET  = 2'd1,
        REQ_INC  = 2'd2,
        REQ_DEC  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        UNIT_YEAR   = 3'd0,
        UNIT_MONTH  = 3'd1,
        UNIT_DAY    = 3'd2,
        UNIT_HOUR   = 3'd3,
        UNIT_MINUTE = 3'd4,
        UNIT_SECOND = 3'd5
    } unit_t;

    // Reset date 1/1/2007 00:00:00
    localparam int                 RESET_YEAR   = 2007;
    localparam logic [DAY_W-1:0]  RESET_DAY    = 5'd1;
    localparam logic [MON_W-1:0]  RESET_MONTH  = 4'd1;

    // Limits used by carries and borrows
    localparam logic [DAY_W-1:0]  DAY_LONG     = 5'd31;
    localparam logic [DAY_W-1:0]  DAY_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0]  DAY_FEB      = 5'd28;
    localparam logic [DAY_W-1:0]  DAY_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0]  DAY_PLAIN    = 5'd27;
    localparam logic [MON_W-1:0]  MON_FEB      = 4'd2;
    localparam logic [MON_W-1:0]  MON_MAR      = 4'd3;
    localparam logic [MON_W-1:0]  MON_DEC      = 4'd12;
    localparam logic [HOUR_W-1:0] HOUR_MAX     = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_MAX      = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_MAX      = 6'd59;

    // Days in a month; zero for month codes that mean nothing
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_SHORT;
            4'd2:                                       len = leap ? DAY_FEB_LEAP : DAY_FEB;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/ctsc_check.sv =====
// Validity check for a full load of date and time.
// Depends on ctsc_pkg (widths, month_len).
module ctsc_check (
    input  logic [ctsc_pkg::DAY_W-1:0]      new_day,
    input  logic [ctsc_pkg::MON_W-1:0]      new_month,
    input  logic [ctsc_pkg::NEW_YEAR_W-1:0] new_year,
    input  logic [ctsc_pkg::HOUR_W-1:0]     new_hour,
    input  logic [ctsc_pkg::MIN_W-1:0]      new_minute,
    input  logic [ctsc_pkg::SEC_W-1:0]      new_second,
    output logic                            load_ok
);
    import ctsc_pkg::*;

    logic             new_leap;
    logic [DAY_W-1:0] new_len;

    // Leap year every fourth year
    assign new_leap = (new_year[1:0] == 2'b00);
    assign new_len  = month_len(new_month, new_leap);

    // Month range is covered by a nonzero table entry
    assign load_ok = (new_hour <= HOUR_MAX) && (new_minute <= MIN_MAX) &&
                     (new_second <= SEC_MAX) && (new_day != '0) &&
                     (new_len != '0) && (new_day <= new_len);

endmodule

// ===== sv/ctsc_step.sv =====
// Next-state logic of the calendar counter: load, set, increment and decrement.
// Depends on ctsc_pkg and ctsc_check.
module ctsc_step #(
    parameter int YEAR_BITS = 14
) (
    input  logic [1:0]                      req_type,
    input  logic [2:0]                      unit,
    input  logic [ctsc_pkg::DAY_W-1:0]      new_day,
    input  logic [ctsc_pkg::MON_W-1:0]      new_month,
    input  logic [ctsc_pkg::NEW_YEAR_W-1:0] new_year,
    input  logic [ctsc_pkg::HOUR_W-1:0]     new_hour,
    input  logic [ctsc_pkg::MIN_W-1:0]      new_minute,
    input  logic [ctsc_pkg::SEC_W-1:0]      new_second,
    input  logic [ctsc_pkg::DAY_W-1:0]      day,
    input  logic [ctsc_pkg::MON_W-1:0]      month,
    input  logic [YEAR_BITS-1:0]            year,
    input  logic [ctsc_pkg::HOUR_W-1:0]     hour,
    input  logic [ctsc_pkg::MIN_W-1:0]      minute,
    input  logic [ctsc_pkg::SEC_W-1:0]      second,
    output logic [ctsc_pkg::DAY_W-1:0]      day_next,
    output logic [ctsc_pkg::MON_W-1:0]      month_next,
    output logic [YEAR_BITS-1:0]            year_next,
    output logic [ctsc_pkg::HOUR_W-1:0]     hour_next,
    output logic [ctsc_pkg::MIN_W-1:0]      minute_next,
    output logic [ctsc_pkg::SEC_W-1:0]      second_next,
    output logic                            rejected_next
);
    import ctsc_pkg::*;

    logic                  load_ok;
    logic                  leap;
    logic                  roll;
    logic [YEAR_BITS-1:0]  year_inc;
    logic [YEAR_BITS-1:0]  year_dec;
    logic [YEAR_BITS-1:0]  ny;
    // day carry
    logic [DAY_W-1:0]      du_d;
    logic [MON_W-1:0]      du_m;
    logic [YEAR_BITS-1:0]  du_y;
    // day borrow
    logic [DAY_W-1:0]      db_d;
    logic [MON_W-1:0]      db_m;
    logic [YEAR_BITS-1:0]  db_y;
    // hour borrow (day side)
    logic [DAY_W-1:0]      hb_d;
    logic [MON_W-1:0]      hb_m;
    logic [YEAR_BITS-1:0]  hb_y;
    // minute carry / borrow (hour and day side)
    logic [HOUR_W-1:0]     mc_h;
    logic [DAY_W-1:0]      mc_d;
    logic [MON_W-1:0]      mc_m;
    logic [YEAR_BITS-1:0]  mc_y;
    logic [HOUR_W-1:0]     mb_h;
    logic [DAY_W-1:0]      mb_d;
    logic [MON_W-1:0]      mb_m;
    logic [YEAR_BITS-1:0]  mb_y;

    ctsc_check u_check (
        .new_day    (new_day),
        .new_month  (new_month),
        .new_year   (new_year),
        .new_hour   (new_hour),
        .new_minute (new_minute),
        .new_second (new_second),
        .load_ok    (load_ok)
    );

    assign leap     = (year[1:0] == 2'b00);
    assign year_inc = year + YEAR_BITS'(1);
    assign year_dec = year - YEAR_BITS'(1);
    assign ny       = YEAR_BITS'(new_year);

    // Day carry, month end rule above day 27
    always_comb
    begin
        du_d = day + 5'd1;
        du_m = month;
        du_y = year;
        case (day)
            DAY_FEB:      roll = (month == MON_FEB) && !leap;
            DAY_FEB_LEAP: roll = (month == MON_FEB);
            DAY_SHORT:    roll = month inside {4'd4, 4'd6, 4'd9, 4'd11};
            default:      roll = 1'b1;
        endcase
        if ((day > DAY_PLAIN) && roll)
        begin
            du_d = RESET_DAY;
            if (month == MON_DEC)
            begin
                du_m = RESET_MONTH;
                du_y = year_inc;
            end
            else
            begin
                du_m = month + 4'd1;
            end
        end
    end

    // Day borrow into the previous month
    always_comb
    begin
        db_y = year;
        db_m = month - 4'd1;
        db_d = DAY_LONG;
        if (month == RESET_MONTH)
        begin
            db_y = year_dec;
            db_m = MON_DEC;
        end
        else if (month == MON_MAR)
        begin
            db_d = leap ? DAY_FEB_LEAP : DAY_FEB;
        end
        else if (month inside {4'd5, 4'd7, 4'd10, 4'd12})
        begin
            db_d = DAY_SHORT;
        end
    end

    // Hour borrow: day side
    always_comb
    begin
        if (day > 5'd1)
        begin
            hb_d = day - 5'd1;
            hb_m = month;
            hb_y = year;
        end
        else
        begin
            hb_d = db_d;
            hb_m = db_m;
            hb_y = db_y;
        end
    end

    // Minute carry and borrow: hour and day side
    always_comb
    begin
        if (hour < HOUR_MAX)
        begin
            mc_h = hour + 5'd1;
            mc_d = day;
            mc_m = month;
            mc_y = year;
        end
        else
        begin
            mc_h = '0;
            mc_d = du_d;
            mc_m = du_m;
            mc_y = du_y;
        end
        if (hour != '0)
        begin
            mb_h = hour - 5'd1;
            mb_d = day;
            mb_m = month;
            mb_y = year;
        end
        else
        begin
            mb_h = HOUR_MAX;
            mb_d = hb_d;
            mb_m = hb_m;
            mb_y = hb_y;
        end
    end

    // Request select
    always_comb
    begin
        day_next      = day;
        month_next    = month;
        year_next     = year;
        hour_next     = hour;
        minute_next   = minute;
        second_next   = second;
        rejected_next = 1'b0;
        case (req_type)
            REQ_LOAD:
            begin
                if (load_ok)
                begin
                    day_next    = new_day;
                    month_next  = new_month;
                    year_next   = ny;
                    hour_next   = new_hour;
                    minute_next = new_minute;
                    second_next = new_second;
                end
                else
                begin
                    day_next      = RESET_DAY;
                    month_next    = RESET_MONTH;
                    year_next     = YEAR_BITS'(RESET_YEAR);
                    hour_next     = '0;
                    minute_next   = '0;
                    second_next   = '0;
                    rejected_next = 1'b1;
                end
            end
            REQ_SET:
            begin
                case (unit)
                    UNIT_YEAR:   year_next   = ny;
                    UNIT_MONTH:  month_next  = new_month;
                    UNIT_DAY:    day_next    = new_day;
                    UNIT_HOUR:   hour_next   = new_hour;
                    UNIT_MINUTE: minute_next = new_minute;
                    UNIT_SECOND: second_next = new_second;
                    default:     ;
                endcase
            end
            REQ_INC:
            begin
                case (unit)
                    UNIT_YEAR: year_next = year_inc;
                    UNIT_MONTH:
                    begin
                        if (month == MON_DEC)
                        begin
                            year_next  = year_inc;
                            month_next = RESET_MONTH;
                        end
                        else
                        begin
                            month_next = month + 4'd1;
                        end
                    end
                    UNIT_DAY:
                    begin
                        day_next   = du_d;
                        month_next = du_m;
                        year_next  = du_y;
                    end
                    UNIT_HOUR:
                    begin
                        if (hour == HOUR_MAX)
                        begin
                            hour_next  = '0;
                            day_next   = du_d;
                            month_next = du_m;
                            year_next  = du_y;
                        end
                        else
                        begin
                            hour_next = hour + 5'd1;
                        end
                    end
                    UNIT_MINUTE:
                    begin
                        if (minute == MIN_MAX)
                        begin
                            minute_next = '0;
                            hour_next   = mc_h;
                            day_next    = mc_d;
                            month_next  = mc_m;
                            year_next   = mc_y;
                        end
                        else
                        begin
                            minute_next = minute + 6'd1;
                        end
                    end
                    UNIT_SECOND:
                    begin
                        if (second == SEC_MAX)
                        begin
                            second_next = '0;
                            if (minute < MIN_MAX)
                            begin
                                minute_next = minute + 6'd1;
                            end
                            else
                            begin
                                minute_next = '0;
                                hour_next   = mc_h;
                                day_next    = mc_d;
                                month_next  = mc_m;
                                year_next   = mc_y;
                            end
                        end
                        else
                        begin
                            second_next = second + 6'd1;
                        end
                    end
                    default: ;
                endcase
            end
            default:
            begin
                // decrement
                case (unit)
                    UNIT_YEAR:
                    begin
                        if (year != '0)
                        begin
                            year_next = year_dec;
                        end
                    end
                    UNIT_MONTH:
                    begin
                        if (month == RESET_MONTH)
                        begin
                            year_next  = year_dec;
                            month_next = MON_DEC;
                        end
                        else
                        begin
                            month_next = month - 4'd1;
                        end
                    end
                    UNIT_DAY:
                    begin
                        if (day == RESET_DAY)
                        begin
                            day_next   = db_d;
                            month_next = db_m;
                            year_next  = db_y;
                        end
                        else
                        begin
                            day_next = day - 5'd1;
                        end
                    end
                    UNIT_HOUR:
                    begin
                        if (hour == '0)
                        begin
                            hour_next  = HOUR_MAX;
                            day_next   = hb_d;
                            month_next = hb_m;
                            year_next  = hb_y;
                        end
                        else
                        begin
                            hour_next = hour - 5'd1;
                        end
                    end
                    UNIT_MINUTE:
                    begin
                        if (minute == '0)
                        begin
                            minute_next = MIN_MAX;
                            hour_next   = mb_h;
                            day_next    = mb_d;
                            month_next  = mb_m;
                            year_next   = mb_y;
                        end
                        else
                        begin
                            minute_next = minute - 6'd1;
                        end
                    end
                    UNIT_SECOND:
                    begin
                        if (second == '0)
                        begin
                            second_next = SEC_MAX;
                            if (minute != '0)
                            begin
                                minute_next = minute - 6'd1;
                            end
                            else
                            begin
                                minute_next = MIN_MAX;
                                hour_next   = mb_h;
                                day_next    = mb_d;
                                month_next  = mb_m;
                                year_next   = mb_y;
                            end
                        end
                        else
                        begin
                            second_next = second - 6'd1;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

endmodule

// ===== sv/calendar_time_step_counter_top.sv =====
// Top level of the calendar time step counter: input register, step logic, result register.
// Depends on ctsc_pkg and ctsc_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: req_type, unit and
//   the new_* fields. Output channel (out_valid/out_ready) carries one result item
//   per request: the six cur_* fields held after the request and load_rejected.
//   A request accepted into the request register moves on into the result register
//   when that stage is free. Throughput: one item per cycle while the receiver takes
//   each result, set by the single pass through the step logic between the request
//   register and the calendar registers.
//   The calendar registers double as the result register; they change only when a
//   request moves into the result stage.
//   Reset: rst_n low clears both stages and sets the date to 1/1/2007 00:00:00.
//   Stall: while out_ready is low the result holds; one more request is taken into
//   the request register and in_ready then drops until the result is taken.
module calendar_time_step_counter_top #(
    parameter int YEAR_BITS = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [2:0]                      unit,
    input  logic [ctsc_pkg::DAY_W-1:0]      new_day,
    input  logic [ctsc_pkg::MON_W-1:0]      new_month,
    input  logic [ctsc_pkg::NEW_YEAR_W-1:0] new_year,
    input  logic [ctsc_pkg::HOUR_W-1:0]     new_hour,
    input  logic [ctsc_pkg::MIN_W-1:0]      new_minute,
    input  logic [ctsc_pkg::SEC_W-1:0]      new_second,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ctsc_pkg::DAY_W-1:0]      cur_day,
    output logic [ctsc_pkg::MON_W-1:0]      cur_month,
    output logic [YEAR_BITS-1:0]            cur_year,
    output logic [ctsc_pkg::HOUR_W-1:0]     cur_hour,
    output logic [ctsc_pkg::MIN_W-1:0]      cur_minute,
    output logic [ctsc_pkg::SEC_W-1:0]      cur_second,
    output logic                            load_rejected
);
    import ctsc_pkg::*;

    // Request register
    logic                  req_valid_reg;
    logic [1:0]            req_type_reg;
    logic [2:0]            unit_reg;
    logic [DAY_W-1:0]      new_day_reg;
    logic [MON_W-1:0]      new_month_reg;
    logic [NEW_YEAR_W-1:0] new_year_reg;
    logic [HOUR_W-1:0]     new_hour_reg;
    logic [MIN_W-1:0]      new_minute_reg;
    logic [SEC_W-1:0]      new_second_reg;

    // Calendar / result registers
    logic                  out_valid_reg;
    logic                  rejected_reg;
    logic [DAY_W-1:0]      day_reg;
    logic [MON_W-1:0]      month_reg;
    logic [YEAR_BITS-1:0]  year_reg;
    logic [HOUR_W-1:0]     hour_reg;
    logic [MIN_W-1:0]      minute_reg;
    logic [SEC_W-1:0]      second_reg;

    logic [DAY_W-1:0]      day_next;
    logic [MON_W-1:0]      month_next;
    logic [YEAR_BITS-1:0]  year_next;
    logic [HOUR_W-1:0]     hour_next;
    logic [MIN_W-1:0]      minute_next;
    logic [SEC_W-1:0]      second_next;
    logic                  rejected_next;

    logic                  req_go;
    logic                  in_take;

    // Handshake
    assign req_go   = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || req_go;
    assign in_take  = in_valid && in_ready;

    // Request register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_type_reg   <= req_type;
            unit_reg       <= unit;
            new_day_reg    <= new_day;
            new_month_reg  <= new_month;
            new_year_reg   <= new_year;
            new_hour_reg   <= new_hour;
            new_minute_reg <= new_minute;
            new_second_reg <= new_second;
        end
    end

    ctsc_step #(
        .YEAR_BITS (YEAR_BITS)
    ) u_step (
        .req_type      (req_type_reg),
        .unit          (unit_reg),
        .new_day       (new_day_reg),
        .new_month     (new_month_reg),
        .new_year      (new_year_reg),
        .new_hour      (new_hour_reg),
        .new_minute    (new_minute_reg),
        .new_second    (new_second_reg),
        .day           (day_reg),
        .month         (month_reg),
        .year          (year_reg),
        .hour          (hour_reg),
        .minute        (minute_reg),
        .second        (second_reg),
        .day_next      (day_next),
        .month_next    (month_next),
        .year_next     (year_next),
        .hour_next     (hour_next),
        .minute_next   (minute_next),
        .second_next   (second_next),
        .rejected_next (rejected_next)
    );

    // Calendar state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rejected_reg  <= 1'b0;
            day_reg       <= RESET_DAY;
            month_reg     <= RESET_MONTH;
            year_reg      <= YEAR_BITS'(RESET_YEAR);
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
        end
        else
        begin
            if (req_go)
            begin
                out_valid_reg <= 1'b1;
                rejected_reg  <= rejected_next;
                day_reg       <= day_next;
                month_reg     <= month_next;
                year_reg      <= year_next;
                hour_reg      <= hour_next;
                minute_reg    <= minute_next;
                second_reg    <= second_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign load_rejected = rejected_reg;
    assign cur_day       = day_reg;
    assign cur_month     = month_reg;
    assign cur_year      = year_reg;
    assign cur_hour      = hour_reg;
    assign cur_minute    = minute_reg;
    assign cur_second    = second_reg;

`ifndef SYNTHESIS
    // A rejected load always leaves the reset date behind
    a_reject_restores: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rejected_reg) |-> (day_reg == RESET_DAY &&
            month_reg == RESET_MONTH && year_reg == YEAR_BITS'(RESET_YEAR) &&
            hour_reg == '0 && minute_reg == '0 && second_reg == '0))
        else $error("rejected load did not restore reset date");

    // A request moving on always shows up as a result in the next cycle
    a_go_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_go |=> out_valid_reg)
        else $error("request advanced without a result");

    // Calendar state only changes when a request moves into the result stage
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !req_go |=> ($stable(day_reg) && $stable(month_reg) && $stable(year_reg) &&
            $stable(hour_reg) && $stable(minute_reg) && $stable(second_reg)))
        else $error("calendar changed without a request");

    // Input is refused only while a request waits in the request register
    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (req_valid_reg && out_valid_reg && !out_ready))
        else $error("input refused while a stage was free");
`endif

endmodule

// ===== tb/calendar_step_checker.sv =====
// Checker for the calendar time step counter: watches both channels, predicts each result
// from its own copy of the calendar and compares the results field by field.
// Depends on ctsc_pkg.
module calendar_step_checker #(
    parameter int YEAR_W = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [2:0]                      unit,
    input  logic [ctsc_pkg::DAY_W-1:0]      new_day,
    input  logic [ctsc_pkg::MON_W-1:0]      new_month,
    input  logic [ctsc_pkg::NEW_YEAR_W-1:0] new_year,
    input  logic [ctsc_pkg::HOUR_W-1:0]     new_hour,
    input  logic [ctsc_pkg::MIN_W-1:0]      new_minute,
    input  logic [ctsc_pkg::SEC_W-1:0]      new_second,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [ctsc_pkg::DAY_W-1:0]      cur_day,
    input  logic [ctsc_pkg::MON_W-1:0]      cur_month,
    input  logic [YEAR_W-1:0]               cur_year,
    input  logic [ctsc_pkg::HOUR_W-1:0]     cur_hour,
    input  logic [ctsc_pkg::MIN_W-1:0]      cur_minute,
    input  logic [ctsc_pkg::SEC_W-1:0]      cur_second,
    input  logic                            load_rejected,
    output int                              fail_count,
    output int                              pending,
    output int                              n_requests,
    output int                              n_results,
    output int                              n_rejected
);
    import ctsc_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic              rejected;
    } calendar_t;

    // Predicted calendar and the results still owed by the block
    logic [DAY_W-1:0]  cal_day;
    logic [MON_W-1:0]  cal_month;
    logic [YEAR_W-1:0] cal_year;
    logic [HOUR_W-1:0] cal_hour;
    logic [MIN_W-1:0]  cal_minute;
    logic [SEC_W-1:0]  cal_second;
    calendar_t         owed_q[$];

    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        return y[1:0] == 2'b00;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                                    n = leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                 n = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            default:                                 n = '0;
        endcase
        return n;
    endfunction

    function automatic void restore_default();
        cal_day    = RESET_DAY;
        cal_month  = RESET_MONTH;
        cal_year   = YEAR_W'(RESET_YEAR);
        cal_hour   = '0;
        cal_minute = '0;
        cal_second = '0;
    endfunction

    // Day forward; days 28..31 may roll into the next month
    function automatic void day_forward();
        logic roll;
        if (cal_day > DAY_PLAIN) begin
            case (cal_day)
                5'd28:   roll = (cal_month == MON_FEB) && !leap_year(cal_year);
                5'd29:   roll = (cal_month == MON_FEB);
                5'd30:   roll = cal_month inside {4'd4, 4'd6, 4'd9, 4'd11};
                default: roll = 1'b1;
            endcase
            if (!roll) begin
                cal_day = cal_day + 1'b1;
            end else begin
                cal_day = 5'd1;
                if (cal_month == MON_DEC) begin
                    cal_month = 4'd1;
                    cal_year  = cal_year + 1'b1;
                end else begin
                    cal_month = cal_month + 1'b1;
                end
            end
        end else begin
            cal_day = cal_day + 1'b1;
        end
    endfunction

    // Day back across a month start: land on the last day of the month before
    function automatic void day_back_over();
        case (cal_month)
            4'd1:
            begin
                cal_year  = cal_year - 1'b1;
                cal_month = MON_DEC;
                cal_day   = 5'd31;
            end
            MON_MAR:
            begin
                cal_month = MON_FEB;
                cal_day   = leap_year(cal_year) ? 5'd29 : 5'd28;
            end
            4'd5, 4'd7, 4'd10, 4'd12:
            begin
                cal_month = cal_month - 1'b1;
                cal_day   = 5'd30;
            end
            default:
            begin
                cal_month = cal_month - 1'b1;
                cal_day   = 5'd31;
            end
        endcase
    endfunction

    function automatic void hour_over();
        cal_hour = '0;
        day_forward();
    endfunction

    function automatic void minute_over();
        cal_minute = '0;
        if (cal_hour < HOUR_MAX) cal_hour = cal_hour + 1'b1;
        else hour_over();
    endfunction

    function automatic void second_over();
        cal_second = '0;
        if (cal_minute < MIN_MAX) cal_minute = cal_minute + 1'b1;
        else minute_over();
    endfunction

    function automatic void hour_under();
        cal_hour = HOUR_MAX;
        if (cal_day > 5'd1) cal_day = cal_day - 1'b1;
        else day_back_over();
    endfunction

    function automatic void minute_under();
        cal_minute = MIN_MAX;
        if (cal_hour > 0) cal_hour = cal_hour - 1'b1;
        else hour_under();
    endfunction

    function automatic void second_under();
        cal_second = SEC_MAX;
        if (cal_minute > 0) cal_minute = cal_minute - 1'b1;
        else minute_under();
    endfunction

    function automatic void count_up(input logic [2:0] u);
        case (u)
            UNIT_YEAR:   cal_year = cal_year + 1'b1;
            UNIT_MONTH:
            begin
                if (cal_month == MON_DEC) begin
                    cal_year  = cal_year + 1'b1;
                    cal_month = 4'd1;
                end else begin
                    cal_month = cal_month + 1'b1;
                end
            end
            UNIT_DAY:    day_forward();
            UNIT_HOUR:   if (cal_hour == HOUR_MAX) hour_over(); else cal_hour = cal_hour + 1'b1;
            UNIT_MINUTE:
                if (cal_minute == MIN_MAX) minute_over(); else cal_minute = cal_minute + 1'b1;
            UNIT_SECOND:
                if (cal_second == SEC_MAX) second_over(); else cal_second = cal_second + 1'b1;
            default: ;
        endcase
    endfunction

    function automatic void count_down(input logic [2:0] u);
        case (u)
            // year saturates at zero on a direct decrement
            UNIT_YEAR:   if (cal_year != 0) cal_year = cal_year - 1'b1;
            UNIT_MONTH:
            begin
                if (cal_month == 4'd1) begin
                    cal_year  = cal_year - 1'b1;
                    cal_month = MON_DEC;
                end else begin
                    cal_month = cal_month - 1'b1;
                end
            end
            UNIT_DAY:    if (cal_day == 5'd1) day_back_over(); else cal_day = cal_day - 1'b1;
            UNIT_HOUR:   if (cal_hour == 0) hour_under(); else cal_hour = cal_hour - 1'b1;
            UNIT_MINUTE: if (cal_minute == 0) minute_under(); else cal_minute = cal_minute - 1'b1;
            UNIT_SECOND: if (cal_second == 0) second_under(); else cal_second = cal_second - 1'b1;
            default: ;
        endcase
    endfunction

    // Apply one request to the predicted calendar and return what the block must report
    function automatic calendar_t apply_request(input logic [1:0] kind, input logic [2:0] u);
        calendar_t         res;
        logic [YEAR_W-1:0] ny;
        logic              ok;
        ny = YEAR_W'(new_year);
        res.rejected = 1'b0;
        case (kind)
            REQ_LOAD:
            begin
                ok = new_hour < 24 && new_minute < 60 && new_second < 60 &&
                     new_day >= 1 && new_month >= 1 && new_month <= 12 &&
                     new_day <= month_days(new_month, ny);
                if (ok) begin
                    cal_day    = new_day;
                    cal_month  = new_month;
                    cal_year   = ny;
                    cal_hour   = new_hour;
                    cal_minute = new_minute;
                    cal_second = new_second;
                end else begin
                    restore_default();
                    res.rejected = 1'b1;
                end
            end
            REQ_SET:
            begin
                case (u)
                    UNIT_YEAR:   cal_year   = ny;
                    UNIT_MONTH:  cal_month  = new_month;
                    UNIT_DAY:    cal_day    = new_day;
                    UNIT_HOUR:   cal_hour   = new_hour;
                    UNIT_MINUTE: cal_minute = new_minute;
                    UNIT_SECOND: cal_second = new_second;
                    default: ;
                endcase
            end
            REQ_INC: count_up(u);
            default: count_down(u);
        endcase
        res.day    = cal_day;
        res.month  = cal_month;
        res.year   = cal_year;
        res.hour   = cal_hour;
        res.minute = cal_minute;
        res.second = cal_second;
        return res;
    endfunction

    // Compare accepted results first, then predict the newly accepted request
    always @(posedge clk or negedge rst_n)
    begin : watch
        calendar_t want;
        if (!rst_n) begin
            restore_default();
            owed_q.delete();
            fail_count = 0;
            pending    = 0;
            n_requests = 0;
            n_results  = 0;
            n_rejected = 0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (owed_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] result with nothing expected: %0d/%0d/%0d %0d:%0d:%0d rej=%0d",
                                 $realtime, cur_day, cur_month, cur_year, cur_hour, cur_minute,
                                 cur_second, load_rejected);
                end else begin
                    want = owed_q.pop_front();
                    if (cur_day !== want.day || cur_month !== want.month ||
                        cur_year !== want.year || cur_hour !== want.hour ||
                        cur_minute !== want.minute || cur_second !== want.second ||
                        load_rejected !== want.rejected) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"[%0t] mismatch: expected %0d/%0d/%0d %0d:%0d:%0d rej=%0d,",
                                      " got %0d/%0d/%0d %0d:%0d:%0d rej=%0d"},
                                     $realtime, want.day, want.month, want.year, want.hour,
                                     want.minute, want.second, want.rejected, cur_day,
                                     cur_month, cur_year, cur_hour, cur_minute, cur_second,
                                     load_rejected);
                    end
                end
            end
            if (in_valid && in_ready) begin
                n_requests++;
                want = apply_request(req_type, unit);
                if (want.rejected) n_rejected++;
                owed_q.push_back(want);
            end
            pending = owed_q.size();
        end
    end

endmodule

// ===== tb/tb_calendar_time_step_counter_top.sv =====
// Testbench top for calendar_time_step_counter_top: clock, reset, request stimulus and verdict.
// Directed boundary requests, then random load-and-step sequences under four idling phases.
// Depends on ctsc_pkg, calendar_time_step_counter_top and calendar_step_checker.
module tb_calendar_time_step_counter_top;
    import ctsc_pkg::*;

    localparam int         YEAR_W      = 14;
    localparam logic [2:0] UNIT_SPARE6 = 3'd6;
    localparam logic [2:0] UNIT_SPARE7 = 3'd7;
    localparam int         PHASE_ITEMS = 275;

    typedef struct {
        req_t                    kind;
        logic [2:0]              sel;
        logic [DAY_W-1:0]        day;
        logic [MON_W-1:0]        month;
        logic [NEW_YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]       hour;
        logic [MIN_W-1:0]        minute;
        logic [SEC_W-1:0]        second;
    } request_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            req_type;
    logic [2:0]            unit;
    logic [DAY_W-1:0]      new_day;
    logic [MON_W-1:0]      new_month;
    logic [NEW_YEAR_W-1:0] new_year;
    logic [HOUR_W-1:0]     new_hour;
    logic [MIN_W-1:0]      new_minute;
    logic [SEC_W-1:0]      new_second;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DAY_W-1:0]      cur_day;
    logic [MON_W-1:0]      cur_month;
    logic [YEAR_W-1:0]     cur_year;
    logic [HOUR_W-1:0]     cur_hour;
    logic [MIN_W-1:0]      cur_minute;
    logic [SEC_W-1:0]      cur_second;
    logic                  load_rejected;

    int fail_count;
    int pending;
    int n_requests;
    int n_results;
    int n_rejected;
    int idle_pct  = 0;
    int stall_pct = 0;
    int useful_items;

    always #5 clk = ~clk;

    calendar_time_step_counter_top #(
        .YEAR_BITS(YEAR_W)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .unit(unit),
        .new_day(new_day), .new_month(new_month), .new_year(new_year),
        .new_hour(new_hour), .new_minute(new_minute), .new_second(new_second),
        .out_valid(out_valid), .out_ready(out_ready),
        .cur_day(cur_day), .cur_month(cur_month), .cur_year(cur_year),
        .cur_hour(cur_hour), .cur_minute(cur_minute), .cur_second(cur_second),
        .load_rejected(load_rejected)
    );

    calendar_step_checker #(
        .YEAR_W(YEAR_W)
    ) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .unit(unit),
        .new_day(new_day), .new_month(new_month), .new_year(new_year),
        .new_hour(new_hour), .new_minute(new_minute), .new_second(new_second),
        .out_valid(out_valid), .out_ready(out_ready),
        .cur_day(cur_day), .cur_month(cur_month), .cur_year(cur_year),
        .cur_hour(cur_hour), .cur_minute(cur_minute), .cur_second(cur_second),
        .load_rejected(load_rejected),
        .fail_count(fail_count), .pending(pending),
        .n_requests(n_requests), .n_results(n_results), .n_rejected(n_rejected)
    );

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Request with every payload bit random
    function automatic request_t random_req(input req_t kind, input logic [2:0] sel);
        request_t it;
        it.kind   = kind;
        it.sel    = sel;
        it.day    = DAY_W'($urandom);
        it.month  = MON_W'($urandom);
        it.year   = NEW_YEAR_W'($urandom);
        it.hour   = HOUR_W'($urandom);
        it.minute = MIN_W'($urandom);
        it.second = SEC_W'($urandom);
        return it;
    endfunction

    function automatic request_t load_req(input int d, input int m, input int y,
                                          input int h, input int mi, input int s);
        request_t it;
        it        = random_req(REQ_LOAD, 3'($urandom));
        it.day    = DAY_W'(d);
        it.month  = MON_W'(m);
        it.year   = NEW_YEAR_W'(y);
        it.hour   = HOUR_W'(h);
        it.minute = MIN_W'(mi);
        it.second = SEC_W'(s);
        return it;
    endfunction

    function automatic request_t set_req(input logic [2:0] sel, input int v);
        request_t it;
        it = random_req(REQ_SET, sel);
        case (sel)
            UNIT_YEAR:   it.year   = NEW_YEAR_W'(v);
            UNIT_MONTH:  it.month  = MON_W'(v);
            UNIT_DAY:    it.day    = DAY_W'(v);
            UNIT_HOUR:   it.hour   = HOUR_W'(v);
            UNIT_MINUTE: it.minute = MIN_W'(v);
            UNIT_SECOND: it.second = SEC_W'(v);
            default: ;
        endcase
        return it;
    endfunction

    // Low end, high end or anything between, a third each
    function automatic int edge_value(input int lo, input int hi);
        int v;
        case ($urandom_range(2))
            0:       v = lo;
            1:       v = hi;
            default: v = $urandom_range(hi, lo);
        endcase
        return v;
    endfunction

    // Load that places the calendar near a rollover; a few end up rejected
    function automatic request_t edge_load();
        int d;
        case ($urandom_range(3))
            0:       d = 1;
            1:       d = $urandom_range(31, 28);
            default: d = $urandom_range(28, 1);
        endcase
        return load_req(d, $urandom_range(12, 1), edge_value(0, 16383),
                        edge_value(0, 23), edge_value(0, 59), edge_value(0, 59));
    endfunction

    // Present one item and hold it until accepted
    task automatic send_req(input request_t it);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= it.kind;
        unit       <= it.sel;
        new_day    <= it.day;
        new_month  <= it.month;
        new_year   <= it.year;
        new_hour   <= it.hour;
        new_minute <= it.minute;
        new_second <= it.second;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (it.kind == REQ_LOAD || it.sel <= UNIT_SECOND) useful_items++;
    endtask

    // Sender holds off until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic run_directed();
        // leap-day rollover and back, then the top year wrapping through zero
        send_req(load_req(29, 2, 2008, 23, 59, 59));
        send_req(random_req(REQ_INC, UNIT_SECOND));
        send_req(random_req(REQ_DEC, UNIT_SECOND));
        send_req(load_req(31, 12, 16383, 23, 59, 59));
        send_req(random_req(REQ_INC, UNIT_SECOND));
        send_req(random_req(REQ_DEC, UNIT_SECOND));
        // each load check failing on its own, then all of them at once
        send_req(load_req(29, 2, 2007, 12, 0, 0));
        send_req(load_req(0, 1, 2000, 0, 0, 0));
        send_req(load_req(1, 0, 2000, 0, 0, 0));
        send_req(load_req(1, 13, 2000, 0, 0, 0));
        send_req(load_req(31, 4, 2000, 0, 0, 0));
        send_req(load_req(1, 1, 2000, 24, 0, 0));
        send_req(load_req(1, 1, 2000, 0, 60, 0));
        send_req(load_req(1, 1, 2000, 0, 0, 60));
        send_req(load_req(31, 15, 16383, 31, 63, 63));
        // unchecked sets, mostly out of range, then plain steps that wrap in the field (the year holds at zero)
        send_req(set_req(UNIT_YEAR, 0));
        send_req(random_req(REQ_DEC, UNIT_YEAR));
        send_req(set_req(UNIT_MONTH, 15));
        send_req(random_req(REQ_INC, UNIT_MONTH));
        send_req(set_req(UNIT_DAY, 0));
        send_req(random_req(REQ_DEC, UNIT_DAY));
        send_req(set_req(UNIT_HOUR, 31));
        send_req(set_req(UNIT_SECOND, 63));
        send_req(random_req(REQ_INC, UNIT_SECOND));
        // spare unit codes change nothing
        send_req(random_req(REQ_INC, UNIT_SPARE6));
        send_req(random_req(REQ_DEC, UNIT_SPARE7));
        send_req(set_req(UNIT_SPARE7, 0));
    endtask

    // Mostly a boundary load followed by a burst of steps; the rest is noise
    task automatic random_sequence();
        req_t       dir;
        logic [2:0] sel;
        int         pick;
        int         burst;
        pick = $urandom_range(99);
        if (pick < 70) begin
            send_req(edge_load());
            dir   = $urandom_range(1) ? REQ_INC : REQ_DEC;
            burst = $urandom_range(8, 1);
            repeat (burst) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: sel = UNIT_SECOND;
                    4, 5:       sel = UNIT_MINUTE;
                    6:          sel = UNIT_HOUR;
                    7:          sel = UNIT_DAY;
                    8:          sel = UNIT_MONTH;
                    default:    sel = UNIT_YEAR;
                endcase
                if ($urandom_range(9) == 0) dir = (dir == REQ_INC) ? REQ_DEC : REQ_INC;
                send_req(random_req(dir, sel));
            end
        end else if (pick < 80) begin
            send_req(random_req(REQ_LOAD, 3'($urandom)));
        end else if (pick < 92) begin
            send_req(random_req(REQ_SET, 3'($urandom)));
        end else begin
            send_req(random_req($urandom_range(1) ? REQ_INC : REQ_DEC, 3'($urandom)));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_LOAD;
        unit       <= '0;
        new_day    <= '0;
        new_month  <= '0;
        new_year   <= '0;
        new_hour   <= '0;
        new_minute <= '0;
        new_second <= '0;
        useful_items = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct <= 0;  end
                1:       begin idle_pct = 62; stall_pct <= 0;  end
                2:       begin idle_pct = 0;  stall_pct <= 62; end
                default: begin idle_pct = 23; stall_pct <= 23; end
            endcase
            useful_items = 0;
            while (useful_items < PHASE_ITEMS) random_sequence();
            drain();
        end

        // catch any stray result
        repeat (10) @(posedge clk);
        $display("run covered %0d requests with %0d results checked, %0d loads rejected,",
                 n_requests, n_results, n_rejected);
        $display("over directed rollovers and four sender/receiver idling phases");
        if (fail_count == 0 && pending == 0) begin
            $display("** calendar_time_step_counter_top: PASSED **");
        end else begin
            $display("** calendar_time_step_counter_top: FAILED **");
        end
        $finish;
    end

    // Hang guard
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", pending);
        $display("** calendar_time_step_counter_top: FAILED **");
        $finish;
    end

endmodule
